// File: rtl/core/rgbm_pkg.sv
// Shared types, constants and helpers for the RGB888 to masked pixel byte converter.
`timescale 1ns / 1ps

package rgbm_pkg;

  localparam int unsigned NumChan   = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned ProdW     = 40;

  localparam logic [ProdW-1:0] RoundBias = 40'd127;

  // channel 0 red, 1 green, 2 blue
  localparam logic [31:0] MaxRst [NumChan] = '{32'hFF, 32'hFF, 32'hFF};
  localparam logic [4:0]  ShRst  [NumChan] = '{5'd16, 5'd8, 5'd0};
  localparam logic [2:0]  BppRst = 3'd4;

  typedef enum logic [2:0] {
    RegRedMask       = 3'd0,
    RegGreenMask     = 3'd1,
    RegBlueMask      = 3'd2,
    RegBytesPerPixel = 3'd3,
    RegMsbFirst      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] max_val;
    logic [4:0]  shift;
  } chan_cfg_t;

  typedef struct packed {
    logic [1:0] last_idx;
    logic       msb_first;
  } fmt_cfg_t;

  // one base-256 digit of a long division by 255: returns {quotient digit, remainder}
  function automatic logic [15:0] div255_step(input logic [7:0] rem, input logic [7:0] digit);
    logic [15:0] t;
    logic [15:0] s;
    logic [7:0]  q;
    logic [15:0] r;
    t = {rem, digit};
    s = t + {8'd0, t[15:8]} + 16'd1;
    q = s[15:8];
    r = t - {q, 8'd0} + {8'd0, q};
    return {q, r[7:0]};
  endfunction

endpackage

// File: rtl/core/rgbm_cfg.sv
// Configuration registers with a serial lowest-set-bit search per channel mask.
`timescale 1ns / 1ps

module rgbm_cfg (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      we_i,
  input  logic [2:0]                                idx_i,
  input  logic [31:0]                               wdata_i,
  output rgbm_pkg::chan_cfg_t [rgbm_pkg::NumChan-1:0] chan_o,
  output rgbm_pkg::fmt_cfg_t                        fmt_o,
  output logic                                      busy_o
);
  import rgbm_pkg::*;

  logic [31:0]        max_q [NumChan];
  logic [31:0]        max_d [NumChan];
  logic [4:0]         sh_q  [NumChan];
  logic [4:0]         sh_d  [NumChan];
  logic [NumChan-1:0] busy_q, busy_d;
  logic [NumChan-1:0] chan_we;
  logic [2:0]         bpp_q, bpp_d;
  logic               msb_q, msb_d;

  always_comb begin
    chan_we = '0;
    bpp_d   = bpp_q;
    msb_d   = msb_q;
    if (we_i) begin
      case (cfg_reg_e'(idx_i))
        RegRedMask:       chan_we[0] = 1'b1;
        RegGreenMask:     chan_we[1] = 1'b1;
        RegBlueMask:      chan_we[2] = 1'b1;
        RegBytesPerPixel: bpp_d = wdata_i[2:0];
        RegMsbFirst:      msb_d = wdata_i[0];
        default: ;
      endcase
    end
    for (int c = 0; c < NumChan; c++) begin
      max_d[c]  = max_q[c];
      sh_d[c]   = sh_q[c];
      busy_d[c] = busy_q[c];
      if (chan_we[c]) begin
        max_d[c]  = wdata_i;
        sh_d[c]   = 5'd0;
        busy_d[c] = 1'b1;
      end else if (busy_q[c]) begin
        if (max_q[c] == 32'd0 || max_q[c][0]) begin
          busy_d[c] = 1'b0;
        end else begin
          max_d[c] = max_q[c] >> 1;
          sh_d[c]  = sh_q[c] + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        max_q[c] <= MaxRst[c];
        sh_q[c]  <= ShRst[c];
      end
      busy_q <= '0;
      bpp_q  <= BppRst;
      msb_q  <= 1'b0;
    end else begin
      for (int c = 0; c < NumChan; c++) begin
        max_q[c] <= max_d[c];
        sh_q[c]  <= sh_d[c];
      end
      busy_q <= busy_d;
      bpp_q  <= bpp_d;
      msb_q  <= msb_d;
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      chan_o[c].max_val = max_q[c];
      chan_o[c].shift   = sh_q[c];
    end
    fmt_o.msb_first = msb_q;
    case (bpp_q)
      3'd0, 3'd1: fmt_o.last_idx = 2'd0;
      3'd2:       fmt_o.last_idx = 2'd1;
      3'd3:       fmt_o.last_idx = 2'd2;
      default:    fmt_o.last_idx = 2'd3;
    endcase
  end

  assign busy_o = |busy_q;

endmodule

// File: rtl/core/rgbm_front.sv
// Front pipeline: accepts pixels, rescales each channel to its field and packs the word.
`timescale 1ns / 1ps

module rgbm_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  input  logic [31:0]                               pixel_i,
  input  rgbm_pkg::chan_cfg_t [rgbm_pkg::NumChan-1:0] chan_i,
  output logic                                      ready_o,
  output logic                                      push_o,
  output logic [31:0]                               packed_o,
  input  logic                                      fifo_full_i
);
  import rgbm_pkg::*;

  logic [3:0]       vld_q, vld_d;
  logic             adv;

  logic [7:0]       s1_byte_q [NumChan];
  logic [ProdW-1:0] s2_x_q    [NumChan];
  logic [ProdW-1:0] s2_x_d    [NumChan];
  logic [15:0]      s3_hi_q   [NumChan];
  logic [15:0]      s3_hi_d   [NumChan];
  logic [7:0]       s3_rem_q  [NumChan];
  logic [7:0]       s3_rem_d  [NumChan];
  logic [15:0]      s3_lo_q   [NumChan];
  logic [31:0]      s4_quot_q [NumChan];
  logic [31:0]      s4_quot_d [NumChan];

  logic [15:0]      st4 [NumChan];
  logic [15:0]      st3 [NumChan];
  logic [15:0]      st2 [NumChan];
  logic [15:0]      st1 [NumChan];
  logic [15:0]      st0 [NumChan];

  assign adv     = !(vld_q[3] && fifo_full_i);
  assign ready_o = adv;
  assign push_o  = vld_q[3] && !fifo_full_i;

  always_comb begin
    vld_d = vld_q;
    if (adv) begin
      vld_d = {vld_q[2:0], in_valid_i};
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      s2_x_d[c] = ProdW'(s1_byte_q[c]) * ProdW'(chan_i[c].max_val) + RoundBias;

      st4[c] = div255_step(8'd0, s2_x_q[c][39:32]);
      st3[c] = div255_step(st4[c][7:0], s2_x_q[c][31:24]);
      st2[c] = div255_step(st3[c][7:0], s2_x_q[c][23:16]);
      s3_hi_d[c]  = {st3[c][15:8], st2[c][15:8]};
      s3_rem_d[c] = st2[c][7:0];

      st1[c] = div255_step(s3_rem_q[c], s3_lo_q[c][15:8]);
      st0[c] = div255_step(st1[c][7:0], s3_lo_q[c][7:0]);
      s4_quot_d[c] = {s3_hi_q[c], st1[c][15:8], st0[c][15:8]};
    end
  end

  always_comb begin
    packed_o = '0;
    for (int c = 0; c < NumChan; c++) begin
      packed_o = packed_o | (s4_quot_q[c] << chan_i[c].shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NumChan; c++) begin
        s1_byte_q[c] <= pixel_i[8*(NumChan-1-c) +: 8];
        s2_x_q[c]    <= s2_x_d[c];
        s3_hi_q[c]   <= s3_hi_d[c];
        s3_rem_q[c]  <= s3_rem_d[c];
        s3_lo_q[c]   <= s2_x_q[c][15:0];
        s4_quot_q[c] <= s4_quot_d[c];
      end
    end
  end

endmodule

// File: rtl/core/rgbm_fifo.sv
// Short queue of packed pixel words between the front and back parts.
`timescale 1ns / 1ps

module rgbm_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [31:0] data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic [31:0] data_o,
  output logic        empty_o
);
  import rgbm_pkg::*;

  logic [31:0]         mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == (FifoPtrW+1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/rgbm_back.sv
// Back part: splits each packed word into bytes and holds the result item.
`timescale 1ns / 1ps

module rgbm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        word_i,
  input  logic               word_empty_i,
  output logic               word_pop_o,
  input  rgbm_pkg::fmt_cfg_t fmt_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         byte_position_o,
  output logic               last_byte_o
);
  import rgbm_pkg::*;

  logic        vld_q, vld_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  idx_q, idx_d;
  logic [1:0]  sel;
  logic        is_last;

  assign is_last = idx_q == fmt_i.last_idx;
  assign sel     = fmt_i.msb_first ? (fmt_i.last_idx - idx_q) : idx_q;

  always_comb begin
    vld_d      = vld_q;
    word_d     = word_q;
    idx_d      = idx_q;
    word_pop_o = 1'b0;
    if (!vld_q || pop_i) begin
      if (vld_q && !is_last) begin
        idx_d = idx_q + 2'd1;
      end else if (!word_empty_i) begin
        word_d     = word_i;
        idx_d      = 2'd0;
        vld_d      = 1'b1;
        word_pop_o = 1'b1;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign empty_o         = !vld_q;
  assign out_byte_o      = word_q[{sel, 3'b000} +: 8];
  assign byte_position_o = idx_q;
  assign last_byte_o     = is_last;

endmodule

// File: rtl/core/rgb888_to_masked_pixel_bytes_core.sv
// Top level of the RGB888 to masked pixel byte converter.
//
// Input queue side: a 0xRRGGBB pixel is taken on pixel_word_i at a clock edge
// with push high and full low. Output queue side: while empty is low the
// oldest byte sits on out_byte_o / byte_position_o / last_byte_o and is taken
// at an edge with pop high. Each pixel gives 1..4 bytes (bytes_per_pixel,
// clamped), in the configured byte order, the final one flagged.
// A pixel passes the front stages (byte capture, product, upper quotient digits,
// full quotient), the word queue and the byte register before its first byte
// appears. The front pipeline takes a pixel every cycle while full is low; the
// byte serializer emits one byte per cycle while pop is high.
// Writing a mask starts a serial lowest-set-bit search; full is held high
// until it ends. Reset restores the 0x00RRGGBB format, four bytes, LSB first,
// with no waiting items. When pop stays low the output holds, the four-word
// queue and the pipeline fill, and full rises.
`timescale 1ns / 1ps

module rgb888_to_masked_pixel_bytes_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] pixel_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  byte_position_o,
  output logic        last_byte_o
);
  import rgbm_pkg::*;

  chan_cfg_t [NumChan-1:0] chan_cfg;
  fmt_cfg_t                fmt_cfg;
  logic                    cfg_busy;
  logic                    front_ready;
  logic                    front_push;
  logic [31:0]             front_word;
  logic                    fifo_full;
  logic                    fifo_empty;
  logic                    fifo_pop;
  logic [31:0]             fifo_word;

  assign full = cfg_busy || !front_ready;

  rgbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .chan_o  (chan_cfg),
    .fmt_o   (fmt_cfg),
    .busy_o  (cfg_busy)
  );

  rgbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push && !full),
    .pixel_i     (pixel_word_i),
    .chan_i      (chan_cfg),
    .ready_o     (front_ready),
    .push_o      (front_push),
    .packed_o    (front_word),
    .fifo_full_i (fifo_full)
  );

  rgbm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_word),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (fifo_word),
    .empty_o (fifo_empty)
  );

  rgbm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .word_i          (fifo_word),
    .word_empty_i    (fifo_empty),
    .word_pop_o      (fifo_pop),
    .fmt_i           (fmt_cfg),
    .empty_o         (empty),
    .pop_i           (pop),
    .out_byte_o      (out_byte_o),
    .byte_position_o (byte_position_o),
    .last_byte_o     (last_byte_o)
  );

endmodule

// File: rtl/core/rgbm_checker.sv
// Port-level checks on the converter's output item sequence, bound to the top level.
`timescale 1ns / 1ps

module rgbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic [1:0] byte_position_o,
  input logic       last_byte_o
);

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(byte_position_o)
                          && $stable(last_byte_o)))
    else $error("stalled output item changed");

  // bytes of one pixel follow each other with no gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_byte_o) |=>
      (!empty && byte_position_o == $past(byte_position_o) + 2'd1))
    else $error("pixel bytes not contiguous");

  // a new pixel starts at position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_byte_o) |=> (empty || byte_position_o == 2'd0))
    else $error("new pixel does not start at position zero");

endmodule

bind rgb888_to_masked_pixel_bytes_core rgbm_checker u_checker (.*);

// File: bench/tb_rgb888_to_masked_pixel_bytes_core.sv
// Testbench for rgb888_to_masked_pixel_bytes_core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_rgb888_to_masked_pixel_bytes_core;
  import rgbm_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned NumDirRows   = 31;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PixPerPhase  = 25;
  localparam logic [2:0]  RegUnusedIdx = 3'd7;

  typedef enum logic {RowPixel, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    bit          typed;
    logic [31:0] word_exp;
  } dir_row_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] pos;
    logic       last;
  } pix_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = RegRedMask;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] pixel_word_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic [1:0]  byte_position_o;
  logic        last_byte_o;

  // predictor copy of the format registers
  logic [31:0] red_mask_q = 32'h00FF0000;
  logic [31:0] green_mask_q = 32'h0000FF00;
  logic [31:0] blue_mask_q = 32'h000000FF;
  logic [2:0]  bpp_q = 3'd4;
  logic        msb_first_q = 1'b0;

  pix_byte_t   byte_q[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  dir_row_t dir_rows [NumDirRows] = '{
    '{RowPixel, RegRedMask,       32'h00FFFFFF, 1'b1, 32'h00FFFFFF},
    '{RowPixel, RegRedMask,       32'h00000000, 1'b1, 32'h00000000},
    '{RowPixel, RegRedMask,       32'hFF123456, 1'b1, 32'h00123456},
    '{RowPixel, RegRedMask,       32'h00A5C35A, 1'b1, 32'h00A5C35A},
    '{RowWrite, RegMsbFirst,      32'h00000001, 1'b0, 32'h0},
    '{RowWrite, RegBytesPerPixel, 32'h00000003, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00123456, 1'b1, 32'h00123456},
    '{RowWrite, RegRedMask,       32'h0000F800, 1'b0, 32'h0},
    '{RowWrite, RegGreenMask,     32'h000007E0, 1'b0, 32'h0},
    '{RowWrite, RegBlueMask,      32'h0000001F, 1'b0, 32'h0},
    '{RowWrite, RegBytesPerPixel, 32'h00000002, 1'b0, 32'h0},
    '{RowWrite, RegMsbFirst,      32'h00000000, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00FFFFFF, 1'b1, 32'h0000FFFF},
    '{RowPixel, RegRedMask,       32'h00808080, 1'b0, 32'h0},
    '{RowWrite, RegRedMask,       32'h00000000, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00FFFFFF, 1'b1, 32'h000007FF},
    '{RowWrite, RegBytesPerPixel, 32'h00000000, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00C0FFEE, 1'b0, 32'h0},
    '{RowWrite, RegBytesPerPixel, 32'h00000007, 1'b0, 32'h0},
    '{RowWrite, RegRedMask,       32'hFFFFFFFF, 1'b0, 32'h0},
    '{RowWrite, RegGreenMask,     32'h80000000, 1'b0, 32'h0},
    '{RowWrite, RegBlueMask,      32'hFFFF0000, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00FFFFFF, 1'b1, 32'hFFFFFFFF},
    '{RowPixel, RegRedMask,       32'h00010000, 1'b0, 32'h0},
    '{RowWrite, RegUnusedIdx,     32'hDEADBEEF, 1'b0, 32'h0},
    '{RowWrite, RegMsbFirst,      32'hFFFFFFFF, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00FF00FF, 1'b0, 32'h0},
    '{RowWrite, RegBytesPerPixel, 32'hFFFFFFF9, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h0000FF00, 1'b0, 32'h0},
    '{RowWrite, RegRedMask,       32'h00000001, 1'b0, 32'h0},
    '{RowPixel, RegRedMask,       32'h00800000, 1'b0, 32'h0}
  };

  rgb888_to_masked_pixel_bytes_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .pixel_word_i   (pixel_word_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .byte_position_o(byte_position_o),
    .last_byte_o    (last_byte_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] scale_channel(input logic [7:0] v, input logic [31:0] mask);
    int unsigned sh;
    logic [63:0] field_max;
    logic [63:0] scaled;
    if (mask == '0) return '0;
    sh = 0;
    while (sh < 31 && mask[sh] == 1'b0) sh++;
    field_max = 64'(mask >> sh);
    scaled = (64'(v) * field_max + 64'd127) / 64'd255;
    return 32'(scaled << sh);
  endfunction

  function automatic logic [31:0] pack_pixel(input logic [31:0] src);
    return scale_channel(src[23:16], red_mask_q) |
           scale_channel(src[15:8], green_mask_q) |
           scale_channel(src[7:0], blue_mask_q);
  endfunction

  task automatic queue_pixel_bytes(input logic [31:0] word);
    int unsigned n;
    int unsigned sel;
    pix_byte_t b;
    n = (bpp_q == 3'd0) ? 1 : ((bpp_q > 3'd4) ? 4 : int'(bpp_q));
    for (int unsigned i = 0; i < n; i++) begin
      sel = msb_first_q ? (n - 1 - i) : i;
      b.data = word[sel*8 +: 8];
      b.pos = 2'(i);
      b.last = (i == n - 1);
      byte_q.push_back(b);
    end
  endtask

  task automatic send_pixel(input logic [31:0] w, input bit typed, input logic [31:0] word_exp);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_word_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    queue_pixel_bytes(typed ? word_exp : pack_pixel(w));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    push <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRedMask:       red_mask_q = d;
      RegGreenMask:     green_mask_q = d;
      RegBlueMask:      blue_mask_q = d;
      RegBytesPerPixel: bpp_q = d[2:0];
      RegMsbFirst:      msb_first_q = d[0];
      default: ;
    endcase
    // mask writes hold full during the shift search
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_mask();
    int unsigned w;
    int unsigned p;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      3: begin
        w = $urandom_range(1, 16);
        p = $urandom_range(0, 32 - w);
        return 32'((64'd1 << w) - 64'd1) << p;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(9))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return 32'h00FFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic check_byte();
    pix_byte_t b;
    if (byte_q.size() == 0) begin
      $error("unexpected byte %0h at position %0d", out_byte_o, byte_position_o);
      errors++;
    end else begin
      b = byte_q.pop_front();
      if (out_byte_o !== b.data) begin
        $error("out_byte expected %0h actual %0h", b.data, out_byte_o);
        errors++;
      end
      if (byte_position_o !== b.pos) begin
        $error("byte_position expected %0d actual %0d", b.pos, byte_position_o);
        errors++;
      end
      if (last_byte_o !== b.last) begin
        $error("last_byte expected %0b actual %0b", b.last, last_byte_o);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_byte();
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowWrite) begin
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_pixel(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].word_exp);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      write_reg(RegRedMask, rand_mask());
      write_reg(RegGreenMask, rand_mask());
      write_reg(RegBlueMask, rand_mask());
      write_reg(RegBytesPerPixel, $urandom);
      write_reg(RegMsbFirst, $urandom);
      if ($urandom_range(3) == 0) write_reg(3'($urandom_range(5, 7)), $urandom);
      for (int k = 0; k < PixPerPhase; k++) send_pixel(rand_pixel(), 1'b0, '0);
    end

    push <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rgbm_pkg.sv
rtl/core/rgbm_cfg.sv
rtl/core/rgbm_front.sv
rtl/core/rgbm_fifo.sv
rtl/core/rgbm_back.sv
rtl/core/rgb888_to_masked_pixel_bytes_core.sv
rtl/core/rgbm_checker.sv
bench/tb_rgb888_to_masked_pixel_bytes_core.sv
